// ----- rtl/core/stsp_pkg.sv -----
package stsp_pkg;

	typedef enum logic [1:0] {
		KIND_APPEND = 2'd0,
		KIND_SNAP   = 2'd1,
		KIND_PICK   = 2'd2,
		KIND_NOP    = 2'd3
	} kind_t;

	localparam int CFG_IDX_BITS = 1;
	localparam int CFG_DATA_BITS = 13;
	localparam logic [CFG_IDX_BITS-1:0] REG_SNAP_RADIUS = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_PICK_THRESHOLD = 1'd1;
	localparam logic [CFG_DATA_BITS-1:0] SNAP_RADIUS_RESET = 13'd10;
	localparam logic [CFG_DATA_BITS-1:0] PICK_THRESHOLD_RESET = 13'd5;

	localparam int HIT_BITS = 6;
	localparam int COUNT_OUT_BITS = 7;

endpackage

// ----- rtl/core/stsp_near.sv -----
// Pipelined point-to-segment distance test. Every
// stage registers its results. Products stay within 32 by 32 bits per cycle.
module stsp_near import stsp_pkg::*; #(
	parameter int COORD_BITS = 13
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [COORD_BITS-1:0]  ax,
	input  logic signed [COORD_BITS-1:0]  ay,
	input  logic signed [COORD_BITS-1:0]  bx,
	input  logic signed [COORD_BITS-1:0]  by,
	input  logic signed [COORD_BITS-1:0]  px,
	input  logic signed [COORD_BITS-1:0]  py,
	input  logic [CFG_DATA_BITS-1:0]      thr,
	output logic                          near
);
	localparam int DB = COORD_BITS + 1;
	localparam int PB = 2 * DB;
	localparam int SB = PB + 1;
	localparam int CB = PB + 1;
	localparam int TB = 2 * CFG_DATA_BITS;
	localparam int WB = 2 * CB;

	// Stage 1: differences.
	logic signed [DB-1:0] dx_s1, dy_s1, wx_s1, wy_s1, ex_s1, ey_s1;
	logic [CFG_DATA_BITS-1:0] thr_s1;
	// Stage 2: products.
	logic signed [PB-1:0] dxx_s2, dyy_s2, wxdx_s2, wydy_s2, wxdy_s2, wydx_s2;
	logic signed [PB-1:0] wxx_s2, wyy_s2, exx_s2, eyy_s2;
	logic [TB-1:0] t2_s2;
	// Stage 3: sums.
	logic [SB-1:0] len2_s3, da2_s3, db2_s3;
	logic signed [SB-1:0] dot_s3;
	logic [CB-1:0] cmag_s3;
	logic [TB-1:0] t2_s3;
	// Stage 4: wide compare.
	logic [WB-1:0] lhs_s4, rhs_s4;
	logic [1:0] mode_s4;
	logic [SB-1:0] da2_s4, db2_s4;
	logic [TB-1:0] t2_s4;

	logic signed [CB-1:0] cross_c;
	always_comb cross_c = CB'(wxdy_s2) - CB'(wydx_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= DB'(bx) - DB'(ax);
			dy_s1 <= DB'(by) - DB'(ay);
			wx_s1 <= DB'(px) - DB'(ax);
			wy_s1 <= DB'(py) - DB'(ay);
			ex_s1 <= DB'(px) - DB'(bx);
			ey_s1 <= DB'(py) - DB'(by);
			thr_s1 <= thr;

			dxx_s2 <= dx_s1 * dx_s1;
			dyy_s2 <= dy_s1 * dy_s1;
			wxdx_s2 <= wx_s1 * dx_s1;
			wydy_s2 <= wy_s1 * dy_s1;
			wxdy_s2 <= wx_s1 * dy_s1;
			wydx_s2 <= wy_s1 * dx_s1;
			wxx_s2 <= wx_s1 * wx_s1;
			wyy_s2 <= wy_s1 * wy_s1;
			exx_s2 <= ex_s1 * ex_s1;
			eyy_s2 <= ey_s1 * ey_s1;
			t2_s2 <= thr_s1 * thr_s1;

			len2_s3 <= SB'($unsigned(dxx_s2)) + SB'($unsigned(dyy_s2));
			da2_s3 <= SB'($unsigned(wxx_s2)) + SB'($unsigned(wyy_s2));
			db2_s3 <= SB'($unsigned(exx_s2)) + SB'($unsigned(eyy_s2));
			dot_s3 <= SB'(wxdx_s2) + SB'(wydy_s2);
			cmag_s3 <= cross_c[CB-1] ? CB'(-cross_c) : CB'(cross_c);
			t2_s3 <= t2_s2;

			// Squared cross product against squared threshold times squared
			// length; every operand is at most 29 bits wide.
			lhs_s4 <= WB'(cmag_s3) * WB'(cmag_s3);
			rhs_s4 <= WB'(t2_s3) * WB'(len2_s3);
			if (len2_s3 == '0) begin
				mode_s4 <= 2'd3;
			end else if (dot_s3 <= 0) begin
				mode_s4 <= 2'd0;
			end else if (dot_s3 >= $signed({1'b0, len2_s3})) begin
				mode_s4 <= 2'd1;
			end else begin
				mode_s4 <= 2'd2;
			end
			da2_s4 <= da2_s3;
			db2_s4 <= db2_s3;
			t2_s4 <= t2_s3;
		end
	end

	always_comb begin
		case (mode_s4)
			2'd0:    near = SB'(da2_s4) <= SB'(t2_s4);
			2'd1:    near = SB'(db2_s4) <= SB'(t2_s4);
			2'd2:    near = lhs_s4 <= rhs_s4;
			default: near = 1'b0;
		endcase
	end

endmodule

// ----- rtl/core/segment_table_snap_and_pick_unit.sv -----
// Channel   | Signals                                       | Direction
// ----------+-----------------------------------------------+----------
// input     | in_valid, in_ready, kind, first_*, second_*   | in
// result    | out_valid, out_ready, found, result_*, ...    | out
// config    | cfg_we, cfg_index, cfg_data                   | in
//
// An append writes its entry in the cycle it is accepted. A snap reads one
// segment per cycle from the store. A pick streams segments through the
// four-stage distance pipeline, then closes the gap with a read state and
// a write state per moved entry. The single-port segment memory sets this
// order. Reset clears the count, the config registers and the control
// state; the memory holds garbage until written. The output register holds
// one finished transaction, so the next one is taken while it waits; a
// second finished result stalls in DONE until it drains.
module segment_table_snap_and_pick_unit import stsp_pkg::*; #(
	parameter int MAX_SEGMENTS = 64,
	parameter int COORD_BITS = 13
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     kind,
	input  logic signed [COORD_BITS-1:0]   first_x,
	input  logic signed [COORD_BITS-1:0]   first_y,
	input  logic signed [COORD_BITS-1:0]   second_x,
	input  logic signed [COORD_BITS-1:0]   second_y,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           found,
	output logic signed [COORD_BITS-1:0]   result_x,
	output logic signed [COORD_BITS-1:0]   result_y,
	output logic [HIT_BITS-1:0]            hit_index,
	output logic                           dropped,
	output logic [COUNT_OUT_BITS-1:0]      segment_count,
	input  logic                           cfg_we,
	input  logic [CFG_IDX_BITS-1:0]        cfg_index,
	input  logic [CFG_DATA_BITS-1:0]       cfg_data
);
	localparam int AB = $clog2(MAX_SEGMENTS);
	localparam int NB = $clog2(MAX_SEGMENTS + 1);
	localparam int EW = 4 * COORD_BITS;
	localparam int MB = COORD_BITS + 2;
	localparam int PIPE = 4;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SNAP, ST_PICK, ST_MOVE_RD, ST_MOVE_WR, ST_DONE
	} state_t;

	state_t state_q;
	logic [EW-1:0] mem [MAX_SEGMENTS];
	logic [EW-1:0] rdata_q;
	logic [AB-1:0] raddr;
	logic          ren;
	logic          wen;
	logic [AB-1:0] waddr;
	logic [EW-1:0] wdata;

	logic [NB-1:0] count_q;
	logic [CFG_DATA_BITS-1:0] snap_radius_q, pick_threshold_q;
	logic signed [COORD_BITS-1:0] px_q, py_q;
	logic [NB-1:0] rd_q;       // next index to read
	logic          rv_q;       // rdata_q holds a valid entry this cycle
	logic [AB-1:0] ridx_q;     // index of entry in rdata_q
	logic [PIPE-1:0] pv_q;     // valid bits along the distance pipeline
	logic [AB-1:0] pidx_q [PIPE];
	logic [AB-1:0] hit_q;
	logic [NB-1:0] mv_q;       // gap-closing destination index
	// Result of the transaction being worked on, copied to the outputs in DONE.
	logic          found_q, dropped_q;
	logic signed [COORD_BITS-1:0] rx_q, ry_q;

	// Memory: one read or one write per cycle, registered read data.
	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= wdata;
		end
		if (ren) begin
			rdata_q <= mem[raddr];
		end
	end

	logic signed [COORD_BITS-1:0] sax, say, sbx, sby;
	assign sax = rdata_q[EW-1 -: COORD_BITS];
	assign say = rdata_q[EW-1-COORD_BITS -: COORD_BITS];
	assign sbx = rdata_q[2*COORD_BITS-1 -: COORD_BITS];
	assign sby = rdata_q[COORD_BITS-1:0];

	function automatic logic [MB-1:0] manh(input logic signed [COORD_BITS-1:0] a,
			input logic signed [COORD_BITS-1:0] b, input logic signed [COORD_BITS-1:0] c,
			input logic signed [COORD_BITS-1:0] d);
		logic signed [COORD_BITS:0] u, v;
		logic [COORD_BITS:0] mu, mv;
		u = (COORD_BITS+1)'(a) - (COORD_BITS+1)'(c);
		v = (COORD_BITS+1)'(b) - (COORD_BITS+1)'(d);
		mu = u[COORD_BITS] ? (COORD_BITS+1)'(-u) : (COORD_BITS+1)'(u);
		mv = v[COORD_BITS] ? (COORD_BITS+1)'(-v) : (COORD_BITS+1)'(v);
		return MB'(mu) + MB'(mv);
	endfunction

	logic hit_a, hit_b;
	assign hit_a = manh(sax, say, px_q, py_q) <= MB'(snap_radius_q);
	assign hit_b = manh(sbx, sby, px_q, py_q) <= MB'(snap_radius_q);

	logic near;
	stsp_near #(.COORD_BITS(COORD_BITS)) u_near (
		.clk(clk), .en(1'b1), .ax(sax), .ay(say), .bx(sbx), .by(sby),
		.px(px_q), .py(py_q), .thr(pick_threshold_q), .near(near)
	);

	logic accept_in;
	assign accept_in = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);

	// Memory port control.
	always_comb begin
		ren = 1'b0;
		raddr = rd_q[AB-1:0];
		wen = 1'b0;
		waddr = mv_q[AB-1:0];
		wdata = rdata_q;
		case (state_q)
			ST_IDLE: begin
				waddr = count_q[AB-1:0];
				wdata = {first_x, first_y, second_x, second_y};
				wen = accept_in && kind_t'(kind) == KIND_APPEND
					&& count_q < NB'(MAX_SEGMENTS);
			end
			ST_SNAP: ren = rd_q < count_q;
			ST_PICK: ren = rd_q < count_q;
			ST_MOVE_RD: begin
				raddr = AB'(mv_q + NB'(1));
				ren = 1'b1;
			end
			ST_MOVE_WR: wen = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			snap_radius_q <= SNAP_RADIUS_RESET;
			pick_threshold_q <= PICK_THRESHOLD_RESET;
			out_valid <= 1'b0;
			rv_q <= 1'b0;
			pv_q <= '0;
			rd_q <= '0;
			mv_q <= '0;
		end else begin
			if (cfg_we && cfg_index == REG_SNAP_RADIUS) snap_radius_q <= cfg_data;
			if (cfg_we && cfg_index == REG_PICK_THRESHOLD) pick_threshold_q <= cfg_data;
			if (out_valid && out_ready) out_valid <= 1'b0;
			rv_q <= ren && (state_q == ST_SNAP || state_q == ST_PICK);
			ridx_q <= rd_q[AB-1:0];
			pv_q <= {pv_q[PIPE-2:0], rv_q && state_q == ST_PICK};
			pidx_q[0] <= ridx_q;
			for (int k = 1; k < PIPE; k++) pidx_q[k] <= pidx_q[k-1];
			if (ren) rd_q <= rd_q + NB'(1);
			case (state_q)
				ST_IDLE: begin
					if (accept_in) begin
						px_q <= first_x;
						py_q <= first_y;
						rx_q <= first_x;
						ry_q <= first_y;
						found_q <= 1'b0;
						hit_q <= '0;
						dropped_q <= 1'b0;
						rd_q <= '0;
						case (kind_t'(kind))
							KIND_APPEND: begin
								if (count_q < NB'(MAX_SEGMENTS)) count_q <= count_q + NB'(1);
								else dropped_q <= 1'b1;
								state_q <= ST_DONE;
							end
							KIND_SNAP: state_q <= ST_SNAP;
							KIND_PICK: state_q <= ST_PICK;
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_SNAP: begin
					if (rv_q && (hit_a || hit_b)) begin
						found_q <= 1'b1;
						hit_q <= ridx_q;
						rx_q <= hit_a ? sax : sbx;
						ry_q <= hit_a ? say : sby;
						state_q <= ST_DONE;
					end else if (!rv_q && !ren && rd_q != '0 || count_q == '0) begin
						state_q <= ST_DONE;
					end else if (!rv_q && !ren && rd_q == '0) begin
						state_q <= ST_DONE;
					end
				end
				ST_PICK: begin
					if (pv_q[PIPE-1] && near) begin
						found_q <= 1'b1;
						hit_q <= pidx_q[PIPE-1];
						mv_q <= NB'(pidx_q[PIPE-1]);
						pv_q <= '0;
						rv_q <= 1'b0;
						count_q <= count_q - NB'(1);
						if (NB'(pidx_q[PIPE-1]) + NB'(1) < count_q) state_q <= ST_MOVE_RD;
						else state_q <= ST_DONE;
					end else if (!ren && !rv_q && pv_q == '0) begin
						state_q <= ST_DONE;
					end
				end
				ST_MOVE_RD: state_q <= ST_MOVE_WR;
				ST_MOVE_WR: begin
					mv_q <= mv_q + NB'(1);
					if (mv_q + NB'(1) < count_q) state_q <= ST_MOVE_RD;
					else state_q <= ST_DONE;
				end
				ST_DONE: begin
					// Wait here while the previous result is still unaccepted.
					if (!out_valid || out_ready) begin
						found <= found_q;
						result_x <= rx_q;
						result_y <= ry_q;
						hit_index <= HIT_BITS'(hit_q);
						dropped <= dropped_q;
						segment_count <= COUNT_OUT_BITS'(count_q);
						out_valid <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
